[sv/afk_pkg.sv]
// shared types, constants and helpers for the arm camera kinematics block
package afk_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES = 24;
	localparam int ROT_EXTRA = 5;
	localparam int FIFO_DEPTH = 2;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 14;
	localparam int LEN_W = 14;
	localparam int EXT_W = 13;
	localparam int PX_W = 15;
	localparam int IN_W = 16;
	localparam int OUT_W = 16;

	// angles carry 2^21 units per radian
	localparam int ANG_W = 27;
	localparam int XW = 33;
	localparam int VW = 32;
	localparam int RW = 17;
	localparam int POS_W = 20;

	localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(6588397);
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(3294199);
	localparam logic signed [ANG_W-1:0] ANG_TWO_PI = ANG_W'(13176795);
	localparam int GAIN_Q30 = 652032874;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_OFS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_BASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_OFS = 2'd3;

	localparam logic [LEN_W-1:0] RST_LOWER_LEN = LEN_W'(2000);
	localparam logic signed [CFG_W-1:0] RST_LOWER_OFS = CFG_W'(860);
	localparam logic [LEN_W-1:0] RST_UPPER_BASE = LEN_W'(2368);
	localparam logic [LEN_W-1:0] RST_SIDE_OFS = LEN_W'(384);

	typedef struct packed {
		logic signed [ANG_W-1:0] tlow;
		logic signed [ANG_W-1:0] tsight;
		logic signed [ANG_W-1:0] tt;
		logic [LEN_W-1:0] len;
		logic [PX_W-1:0] px;
		logic [LEN_W-1:0] py;
	} afk_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] lower_x;
		logic signed [OUT_W-1:0] lower_y;
		logic signed [OUT_W-1:0] upper_x;
		logic signed [OUT_W-1:0] upper_y;
		logic signed [OUT_W-1:0] camera_x;
		logic signed [OUT_W-1:0] camera_y;
		logic signed [OUT_W-1:0] sight_x;
		logic signed [OUT_W-1:0] sight_y;
	} afk_result_t;

	function automatic int afk_atan(input int i);
		int v;
		unique case (i)
			0: v = 1647099;
			1: v = 972340;
			2: v = 513757;
			3: v = 260791;
			4: v = 130902;
			5: v = 65515;
			6: v = 32765;
			7: v = 16384;
			8: v = 8192;
			9: v = 4096;
			10: v = 2048;
			11: v = 1024;
			12: v = 512;
			13: v = 256;
			14: v = 128;
			15: v = 64;
			16: v = 32;
			17: v = 16;
			18: v = 8;
			19: v = 4;
			20: v = 2;
			21: v = 1;
			default: v = 0;
		endcase
		return v;
	endfunction

	function automatic logic signed [OUT_W-1:0] afk_sat_pos(input logic signed [POS_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		priority if (v > POS_W'(32767)) begin
			r = OUT_W'(32767);
		end else if (v < -POS_W'(32768)) begin
			r = -OUT_W'(32768);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] afk_sat_unit(input logic signed [POS_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		priority if (v > POS_W'(16384)) begin
			r = OUT_W'(16384);
		end else if (v < -POS_W'(16384)) begin
			r = -OUT_W'(16384);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

endpackage

[sv/afk_front.sv]
// front end: config registers, input capture and angle pre-sums
module afk_front import afk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [EXT_W-1:0] extension,
	input logic signed [IN_W-1:0] top_angle,
	input logic signed [IN_W-1:0] bottom_angle,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	output logic item_vld,
	output afk_item_t item
);

	logic [LEN_W-1:0] len_q;
	logic signed [CFG_W-1:0] ofs_q;
	logic [LEN_W-1:0] base_q;
	logic [LEN_W-1:0] side_q;
	logic vld_s1;
	afk_item_t item_s1;
	logic signed [IN_W:0] dlow;
	logic signed [IN_W+1:0] dsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= RST_LOWER_LEN;
			ofs_q <= RST_LOWER_OFS;
			base_q <= RST_UPPER_BASE;
			side_q <= RST_SIDE_OFS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOWER_LEN: len_q <= cfg_data;
				REG_LOWER_OFS: ofs_q <= cfg_data;
				REG_UPPER_BASE: base_q <= cfg_data;
				REG_SIDE_OFS: side_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dlow = (IN_W+1)'(bottom_angle) - (IN_W+1)'(ofs_q);
	// top + bottom - offset, the common part of the upper and sight angles
	assign dsum = (IN_W+2)'(top_angle) + (IN_W+2)'(bottom_angle) - (IN_W+2)'(ofs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.tlow <= ANG_W'(dlow) <<< 8;
			item_s1.tt <= (ANG_W'(dsum) <<< 8) - ANG_PI;
			item_s1.tsight <= ANG_PI - (ANG_W'(dsum) <<< 8);
			item_s1.len <= len_q;
			item_s1.px <= PX_W'(base_q) + PX_W'(extension);
			item_s1.py <= side_q;
		end
	end

	assign item_vld = vld_s1;
	assign item = item_s1;

endmodule

[sv/afk_fifo.sv]
// short queue between front end and back end
module afk_fifo import afk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input afk_item_t push_item,
	input logic pop,
	output logic full,
	output logic head_vld,
	output afk_item_t head
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	afk_item_t mem_q [FIFO_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (AW+1)'(FIFO_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign do_pop = pop && head_vld;
	assign do_push = push && (!full || do_pop);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

[sv/afk_vec.sv]
// pipelined vectoring cordic: radius and angle of the upper link vector
module afk_vec import afk_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic [PX_W-1:0] px,
	input logic [LEN_W-1:0] py,
	output logic signed [VW-1:0] rad_x,
	output logic signed [ANG_W-1:0] phi,
	output logic zero
);

	localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

	logic signed [VW-1:0] x_in;
	logic signed [VW-1:0] y_in;
	logic zero_in;
	logic signed [VW-1:0] x_s [1:N];
	logic signed [VW-1:0] y_s [1:N];
	logic signed [ANG_W-1:0] z_s [1:N];
	logic zero_s [1:N];

	assign x_in = {{(VW-PX_W-14){1'b0}}, px, 14'b0};
	assign y_in = {{(VW-LEN_W-14){1'b0}}, py, 14'b0};
	assign zero_in = (px == '0) && (py == '0);

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [ANG_W-1:0] AT = ANG_W'(afk_atan(i));
		logic signed [VW-1:0] cx;
		logic signed [VW-1:0] cy;
		logic signed [ANG_W-1:0] cz;
		logic czero;
		if (i == 0) begin : g_first
			assign cx = x_in;
			assign cy = y_in;
			assign cz = '0;
			assign czero = zero_in;
		end else begin : g_next
			assign cx = x_s[i];
			assign cy = y_s[i];
			assign cz = z_s[i];
			assign czero = zero_s[i];
		end
		always_ff @(posedge clk) begin
			if (cy >= 0) begin
				x_s[i+1] <= cx + (cy >>> i);
				y_s[i+1] <= cy - (cx >>> i);
				z_s[i+1] <= cz + AT;
			end else begin
				x_s[i+1] <= cx - (cy >>> i);
				y_s[i+1] <= cy + (cx >>> i);
				z_s[i+1] <= cz - AT;
			end
			zero_s[i+1] <= czero;
		end
	end

	assign rad_x = x_s[N];
	assign phi = z_s[N];
	assign zero = zero_s[N];

endmodule

[sv/afk_rot.sv]
// pipelined rotation cordic with range reduction: cos and sin in q2.30
module afk_rot import afk_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic signed [ANG_W-1:0] ang,
	output logic signed [XW-1:0] cos_val,
	output logic signed [XW-1:0] sin_val
);

	localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
	localparam logic signed [XW-1:0] K0 = XW'(GAIN_Q30);

	function automatic logic signed [ANG_W-1:0] wrap(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		priority if (a >= ANG_PI) begin
			r = a - ANG_TWO_PI;
		end else if (a < -ANG_PI) begin
			r = a + ANG_TWO_PI;
		end else begin
			r = a;
		end
		return r;
	endfunction

	logic signed [ANG_W-1:0] w_s1;
	logic signed [ANG_W-1:0] w_s2;
	logic signed [ANG_W-1:0] w_s3;
	logic signed [ANG_W-1:0] r_s4;
	logic neg_s4;
	logic signed [XW-1:0] x_s [1:N];
	logic signed [XW-1:0] y_s [1:N];
	logic signed [ANG_W-1:0] r_s [1:N];
	logic neg_s [1:N];
	logic signed [XW-1:0] cos_q;
	logic signed [XW-1:0] sin_q;

	// three wrap steps bring any reachable angle into [-pi, pi)
	always_ff @(posedge clk) begin
		w_s1 <= wrap(ang);
		w_s2 <= wrap(w_s1);
		w_s3 <= wrap(w_s2);
		priority if (w_s3 > ANG_HALF_PI) begin
			r_s4 <= w_s3 - ANG_PI;
			neg_s4 <= 1'b1;
		end else if (w_s3 < -ANG_HALF_PI) begin
			r_s4 <= w_s3 + ANG_PI;
			neg_s4 <= 1'b1;
		end else begin
			r_s4 <= w_s3;
			neg_s4 <= 1'b0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [ANG_W-1:0] AT = ANG_W'(afk_atan(i));
		logic signed [XW-1:0] cx;
		logic signed [XW-1:0] cy;
		logic signed [ANG_W-1:0] cr;
		logic cneg;
		if (i == 0) begin : g_first
			assign cx = K0;
			assign cy = '0;
			assign cr = r_s4;
			assign cneg = neg_s4;
		end else begin : g_next
			assign cx = x_s[i];
			assign cy = y_s[i];
			assign cr = r_s[i];
			assign cneg = neg_s[i];
		end
		always_ff @(posedge clk) begin
			if (cr >= 0) begin
				x_s[i+1] <= cx - (cy >>> i);
				y_s[i+1] <= cy + (cx >>> i);
				r_s[i+1] <= cr - AT;
			end else begin
				x_s[i+1] <= cx + (cy >>> i);
				y_s[i+1] <= cy - (cx >>> i);
				r_s[i+1] <= cr + AT;
			end
			neg_s[i+1] <= cneg;
		end
	end

	always_ff @(posedge clk) begin
		cos_q <= neg_s[N] ? -x_s[N] : x_s[N];
		sin_q <= neg_s[N] ? -y_s[N] : y_s[N];
	end

	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

[sv/afk_back.sv]
// back end: cordic passes, scaling multiplies, sums and saturation
module afk_back import afk_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic head_vld,
	input afk_item_t head,
	output logic pop,
	output logic done,
	output afk_result_t result
);

	localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
	localparam int LR = N + ROT_EXTRA;
	localparam int BL = 2 * N + 11;
	localparam int PLW = LEN_W + XW + 1;
	localparam int PRW = RW + XW;
	localparam logic signed [VW-1:0] GAIN_V = VW'(GAIN_Q30);
	localparam logic signed [2*VW-1:0] RND43 = (2*VW)'(1) <<< 43;
	localparam logic signed [PLW-1:0] RL29 = PLW'(1) <<< 29;
	localparam logic signed [PRW-1:0] RR29 = PRW'(1) <<< 29;
	localparam logic signed [XW-1:0] RC21 = XW'(1) <<< 21;
	localparam logic signed [XW-1:0] RC15 = XW'(1) <<< 15;

	typedef struct packed {
		logic signed [ANG_W-1:0] tlow;
		logic signed [ANG_W-1:0] tsight;
		logic signed [ANG_W-1:0] tt;
		logic [LEN_W-1:0] len;
	} afk_side_t;

	logic [BL-1:0] vld_q;
	afk_item_t item_s1;
	afk_side_t side_d [1:N];
	logic signed [VW-1:0] vx;
	logic signed [ANG_W-1:0] vphi;
	logic vzero;

	logic signed [ANG_W-1:0] tlow_s2;
	logic signed [ANG_W-1:0] tup_s2;
	logic signed [ANG_W-1:0] tsight_s2;
	logic [LEN_W-1:0] len_s2;
	logic signed [2*VW-1:0] radp_s2;
	logic signed [RW-1:0] rad_c;
	logic signed [RW-1:0] rad_d [1:LR];
	logic [LEN_W-1:0] len_d [1:LR];

	logic signed [XW-1:0] c1, s1, c2, s2, c3, s3;

	logic signed [PLW-1:0] plc_s3, pls_s3;
	logic signed [PRW-1:0] prc_s3, prs_s3;
	logic signed [XW-1:0] c3_s3, s3_s3;

	logic signed [POS_W-1:0] lx_s4, ly_s4, ur_s4, us_s4, cp_s4, sp_s4, vx_s4, vy_s4;
	logic signed [POS_W-1:0] lx_s5, ly_s5, ux_s5, uy_s5, cp_s5, sp_s5, vx_s5, vy_s5;
	afk_result_t res_s6;

	assign pop = head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[BL-2:0], head_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (head_vld) begin
			item_s1 <= head;
		end
	end

	afk_vec #(.STAGES(N)) u_vec (
		.clk(clk),
		.px(item_s1.px),
		.py(item_s1.py),
		.rad_x(vx),
		.phi(vphi),
		.zero(vzero)
	);

	// side data rides along the vectoring pass
	always_ff @(posedge clk) begin
		side_d[1] <= '{tlow: item_s1.tlow, tsight: item_s1.tsight, tt: item_s1.tt,
			len: item_s1.len};
		for (int i = 2; i <= N; i++) begin
			side_d[i] <= side_d[i-1];
		end
	end

	// a zero upper vector has radius and angle zero
	always_ff @(posedge clk) begin
		tlow_s2 <= side_d[N].tlow;
		tsight_s2 <= side_d[N].tsight;
		len_s2 <= side_d[N].len;
		tup_s2 <= (vzero ? '0 : vphi) + side_d[N].tt;
		radp_s2 <= vzero ? '0 : vx * GAIN_V;
	end

	assign rad_c = RW'((radp_s2 + RND43) >>> 44);

	always_ff @(posedge clk) begin
		rad_d[1] <= rad_c;
		len_d[1] <= len_s2;
		for (int i = 2; i <= LR; i++) begin
			rad_d[i] <= rad_d[i-1];
			len_d[i] <= len_d[i-1];
		end
	end

	afk_rot #(.STAGES(N)) u_rot_low (
		.clk(clk), .ang(tlow_s2), .cos_val(c1), .sin_val(s1)
	);

	afk_rot #(.STAGES(N)) u_rot_up (
		.clk(clk), .ang(tup_s2), .cos_val(c2), .sin_val(s2)
	);

	afk_rot #(.STAGES(N)) u_rot_sight (
		.clk(clk), .ang(tsight_s2), .cos_val(c3), .sin_val(s3)
	);

	always_ff @(posedge clk) begin
		plc_s3 <= $signed({1'b0, len_d[LR]}) * c1;
		pls_s3 <= $signed({1'b0, len_d[LR]}) * s1;
		prc_s3 <= rad_d[LR] * c2;
		prs_s3 <= rad_d[LR] * s2;
		c3_s3 <= c3;
		s3_s3 <= s3;
	end

	always_ff @(posedge clk) begin
		lx_s4 <= POS_W'((plc_s3 + RL29) >>> 30);
		ly_s4 <= POS_W'((pls_s3 + RL29) >>> 30);
		ur_s4 <= POS_W'((prc_s3 + RR29) >>> 30);
		us_s4 <= POS_W'((prs_s3 + RR29) >>> 30);
		cp_s4 <= POS_W'((c3_s3 + RC21) >>> 22);
		sp_s4 <= POS_W'((s3_s3 + RC21) >>> 22);
		vx_s4 <= POS_W'((c3_s3 + RC15) >>> 16);
		vy_s4 <= -POS_W'((s3_s3 + RC15) >>> 16);
	end

	always_ff @(posedge clk) begin
		lx_s5 <= lx_s4;
		ly_s5 <= ly_s4;
		ux_s5 <= ur_s4 + lx_s4;
		uy_s5 <= us_s4 + ly_s4;
		cp_s5 <= cp_s4;
		sp_s5 <= sp_s4;
		vx_s5 <= vx_s4;
		vy_s5 <= vy_s4;
	end

	always_ff @(posedge clk) begin
		res_s6.lower_x <= afk_sat_pos(lx_s5);
		res_s6.lower_y <= afk_sat_pos(ly_s5);
		res_s6.upper_x <= afk_sat_pos(ux_s5);
		res_s6.upper_y <= afk_sat_pos(uy_s5);
		res_s6.camera_x <= afk_sat_pos(ux_s5 + cp_s5);
		res_s6.camera_y <= afk_sat_pos(uy_s5 - sp_s5);
		res_s6.sight_x <= afk_sat_unit(vx_s5);
		res_s6.sight_y <= afk_sat_unit(vy_s5);
	end

	assign done = vld_q[BL-1];
	assign result = res_s6;

endmodule

[sv/arm_camera_forward_kinematics.sv]
// the done strobe follows a taken start through the front end, the queue and the back end
// throughput: one pose per cycle; set by the fully pipelined vectoring and rotation cordics
// the output side cannot stall, so busy stays low and the queue never fills
// config writes are taken every cycle (cfg_ready is always high)
// reset clears the valid pipeline and queue and loads the config defaults
module arm_camera_forward_kinematics import afk_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [EXT_W-1:0] extension,
	input logic signed [IN_W-1:0] top_angle,
	input logic signed [IN_W-1:0] bottom_angle,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	output logic done,
	output logic signed [OUT_W-1:0] lower_x,
	output logic signed [OUT_W-1:0] lower_y,
	output logic signed [OUT_W-1:0] upper_x,
	output logic signed [OUT_W-1:0] upper_y,
	output logic signed [OUT_W-1:0] camera_x,
	output logic signed [OUT_W-1:0] camera_y,
	output logic signed [OUT_W-1:0] sight_x,
	output logic signed [OUT_W-1:0] sight_y
);

	logic accept;
	logic item_vld;
	afk_item_t item;
	logic full;
	logic head_vld;
	afk_item_t head;
	logic pop;
	afk_result_t result;

	assign cfg_ready = 1'b1;
	assign busy = full;
	assign accept = start && !busy;

	afk_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.extension(extension),
		.top_angle(top_angle),
		.bottom_angle(bottom_angle),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_vld(item_vld),
		.item(item)
	);

	afk_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(item_vld),
		.push_item(item),
		.pop(pop),
		.full(full),
		.head_vld(head_vld),
		.head(head)
	);

	afk_back #(.STAGES(CORDIC_STAGES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_vld(head_vld),
		.head(head),
		.pop(pop),
		.done(done),
		.result(result)
	);

	assign lower_x = result.lower_x;
	assign lower_y = result.lower_y;
	assign upper_x = result.upper_x;
	assign upper_y = result.upper_y;
	assign camera_x = result.camera_x;
	assign camera_y = result.camera_y;
	assign sight_x = result.sight_x;
	assign sight_y = result.sight_y;

endmodule

[sv/afk_checker.sv]
// port-level checks for the arm camera kinematics block, bound to the top level
module afk_checker #(
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_ready,
	input logic done,
	input logic signed [15:0] sight_x,
	input logic signed [15:0] sight_y
);

	localparam int N = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int LAT = 2 * N + 13;

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("block stalled its input or config side");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted pose produced no result at the expected cycle");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching accepted pose");

	a_sight_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sight_x >= -16'sd16384 && sight_x <= 16'sd16384 &&
			sight_y >= -16'sd16384 && sight_y <= 16'sd16384))
		else $error("sight vector component out of unit range");

endmodule

bind arm_camera_forward_kinematics afk_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_afk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.cfg_ready(cfg_ready),
	.done(done),
	.sight_x(sight_x),
	.sight_y(sight_y)
);
